/* rtl/efmrs_pkg.sv */
package efmrs_pkg;

  // default field widths
  localparam int VEC_WIDTH_DEF = 16;
  localparam int EIG_WIDTH_DEF = 32;

  // candidate space
  localparam int NUM_ORD   = 6;
  localparam int NUM_SIGN  = 4;
  localparam int NUM_CAND  = NUM_ORD * NUM_SIGN;
  localparam int NUM_COMBO = 8;

  // column order codes
  localparam logic [2:0] ORD_012 = 3'd0;
  localparam logic [2:0] ORD_021 = 3'd1;
  localparam logic [2:0] ORD_102 = 3'd2;
  localparam logic [2:0] ORD_120 = 3'd3;
  localparam logic [2:0] ORD_201 = 3'd4;
  localparam logic [2:0] ORD_210 = 3'd5;

  // determinant sign flags, one bit per column-version combination
  typedef struct packed {
    logic [NUM_COMBO-1:0] pos;
    logic [NUM_COMBO-1:0] neg;
  } det_sign_t;

  // source column placed at output column k
  function automatic logic [1:0] perm_col(input logic [2:0] ord, input logic [1:0] k);
    logic [5:0] p;
    case (ord)
      ORD_012: p = {2'd2, 2'd1, 2'd0};
      ORD_021: p = {2'd1, 2'd2, 2'd0};
      ORD_102: p = {2'd2, 2'd0, 2'd1};
      ORD_120: p = {2'd0, 2'd2, 2'd1};
      ORD_201: p = {2'd1, 2'd0, 2'd2};
      ORD_210: p = {2'd0, 2'd1, 2'd2};
      default: p = {2'd2, 2'd1, 2'd0};
    endcase
    return p[2*k +: 2];
  endfunction

  // odd column orders flip the determinant sign
  function automatic logic perm_odd(input logic [2:0] ord);
    logic odd;
    case (ord)
      ORD_021, ORD_102, ORD_210: odd = 1'b1;
      default:                   odd = 1'b0;
    endcase
    return odd;
  endfunction

endpackage

/* rtl/efmrs_in_if.sv */
interface efmrs_in_if import efmrs_pkg::*; #(
  parameter int VW = VEC_WIDTH_DEF,
  parameter int EW = EIG_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [EW-1:0] eigval_0;
  logic signed [EW-1:0] eigval_1;
  logic signed [EW-1:0] eigval_2;
  logic signed [VW-1:0] e_r0c0;
  logic signed [VW-1:0] e_r0c1;
  logic signed [VW-1:0] e_r0c2;
  logic signed [VW-1:0] e_r1c0;
  logic signed [VW-1:0] e_r1c1;
  logic signed [VW-1:0] e_r1c2;
  logic signed [VW-1:0] e_r2c0;
  logic signed [VW-1:0] e_r2c1;
  logic signed [VW-1:0] e_r2c2;

  modport source (
    output valid, eigval_0, eigval_1, eigval_2,
           e_r0c0, e_r0c1, e_r0c2, e_r1c0, e_r1c1, e_r1c2, e_r2c0, e_r2c1, e_r2c2,
    input  ready
  );

  modport sink (
    input  valid, eigval_0, eigval_1, eigval_2,
           e_r0c0, e_r0c1, e_r0c2, e_r1c0, e_r1c1, e_r1c2, e_r2c0, e_r2c1, e_r2c2,
    output ready
  );
endinterface

/* rtl/efmrs_out_if.sv */
interface efmrs_out_if import efmrs_pkg::*; #(
  parameter int VW = VEC_WIDTH_DEF,
  parameter int EW = EIG_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [EW-1:0] out_eigval_0;
  logic signed [EW-1:0] out_eigval_1;
  logic signed [EW-1:0] out_eigval_2;
  logic signed [VW-1:0] o_r0c0;
  logic signed [VW-1:0] o_r0c1;
  logic signed [VW-1:0] o_r0c2;
  logic signed [VW-1:0] o_r1c0;
  logic signed [VW-1:0] o_r1c1;
  logic signed [VW-1:0] o_r1c2;
  logic signed [VW-1:0] o_r2c0;
  logic signed [VW-1:0] o_r2c1;
  logic signed [VW-1:0] o_r2c2;

  modport source (
    output valid, out_eigval_0, out_eigval_1, out_eigval_2,
           o_r0c0, o_r0c1, o_r0c2, o_r1c0, o_r1c1, o_r1c2, o_r2c0, o_r2c1, o_r2c2,
    input  ready
  );

  modport sink (
    input  valid, out_eigval_0, out_eigval_1, out_eigval_2,
           o_r0c0, o_r0c1, o_r0c2, o_r1c0, o_r1c1, o_r1c2, o_r2c0, o_r2c1, o_r2c2,
    output ready
  );
endinterface

/* rtl/efmrs_det.sv */
module efmrs_det import efmrs_pkg::*; #(
  parameter int VW = VEC_WIDTH_DEF,
  parameter int EW = EIG_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [VW-1:0] e_in   [3][3],
  input  logic signed [EW-1:0] eig_in [3],
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [VW-1:0] e_out   [3][3],
  output logic signed [VW-1:0] n_out   [3][3],
  output logic signed [EW-1:0] eig_out [3],
  output det_sign_t            sgn_out
);

  localparam int PW = 2 * VW;
  localparam int CW = 2 * VW + 1;
  localparam int MW = 3 * VW + 1;
  localparam int DW = 3 * VW + 3;
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage payloads
  logic signed [VW-1:0] s1_e [3][3], s1_n [3][3];
  logic signed [VW-1:0] s2_e [3][3], s2_n [3][3];
  logic signed [VW-1:0] s3_e [3][3], s3_n [3][3];
  logic signed [VW-1:0] s4_e [3][3], s4_n [3][3];
  logic signed [EW-1:0] s1_eig [3], s2_eig [3], s3_eig [3], s4_eig [3];
  logic signed [PW-1:0] s1_p  [4][3][2];
  logic signed [CW-1:0] s2_cx [4][3];
  logic signed [MW-1:0] s3_m  [NUM_COMBO][3];
  det_sign_t            s4_sgn;

  logic signed [VW-1:0] n_in   [3][3];
  logic signed [PW-1:0] p_next [4][3][2];
  logic signed [CW-1:0] cx_next [4][3];
  logic signed [MW-1:0] m_next [NUM_COMBO][3];
  det_sign_t            sgn_next;

  // per-stage flow control, bubbles collapse
  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // saturating negation and cross-product partial products
  always_comb begin
    logic [1:0]          qq;
    logic signed [VW-1:0] y1 [3];
    logic signed [VW-1:0] y2 [3];
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        n_in[r][k] = (e_in[r][k] == VMIN) ? VMAX : -e_in[r][k];
      end
    end
    for (int q = 0; q < 4; q++) begin
      qq = 2'(q);
      for (int r = 0; r < 3; r++) begin
        y1[r] = qq[1] ? n_in[r][1] : e_in[r][1];
        y2[r] = qq[0] ? n_in[r][2] : e_in[r][2];
      end
      p_next[q][0][0] = PW'(y1[1]) * PW'(y2[2]);
      p_next[q][0][1] = PW'(y1[2]) * PW'(y2[1]);
      p_next[q][1][0] = PW'(y1[2]) * PW'(y2[0]);
      p_next[q][1][1] = PW'(y1[0]) * PW'(y2[2]);
      p_next[q][2][0] = PW'(y1[0]) * PW'(y2[1]);
      p_next[q][2][1] = PW'(y1[1]) * PW'(y2[0]);
    end
  end

  // cross-product components
  always_comb begin
    for (int q = 0; q < 4; q++) begin
      for (int c = 0; c < 3; c++) begin
        cx_next[q][c] = CW'(s1_p[q][c][0]) - CW'(s1_p[q][c][1]);
      end
    end
  end

  // dot products with the first column, every version combination
  always_comb begin
    logic [2:0]           dd;
    logic signed [VW-1:0] y0;
    for (int d = 0; d < NUM_COMBO; d++) begin
      dd = 3'(d);
      for (int c = 0; c < 3; c++) begin
        y0 = dd[2] ? s2_n[c][0] : s2_e[c][0];
        m_next[d][c] = MW'(y0) * MW'(s2_cx[dd[1:0]][c]);
      end
    end
  end

  // determinant sum and sign
  always_comb begin
    logic signed [DW-1:0] dsum;
    for (int d = 0; d < NUM_COMBO; d++) begin
      dsum = DW'(s3_m[d][0]) + DW'(s3_m[d][1]) + DW'(s3_m[d][2]);
      sgn_next.pos[d] = (dsum > 0);
      sgn_next.neg[d] = dsum[DW-1];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_e   <= e_in;
      s1_n   <= n_in;
      s1_eig <= eig_in;
      s1_p   <= p_next;
    end
    if (rdy2) begin
      s2_e   <= s1_e;
      s2_n   <= s1_n;
      s2_eig <= s1_eig;
      s2_cx  <= cx_next;
    end
    if (rdy3) begin
      s3_e   <= s2_e;
      s3_n   <= s2_n;
      s3_eig <= s2_eig;
      s3_m   <= m_next;
    end
    if (rdy4) begin
      s4_e   <= s3_e;
      s4_n   <= s3_n;
      s4_eig <= s3_eig;
      s4_sgn <= sgn_next;
    end
  end

  assign out_valid = v4;
  assign e_out     = s4_e;
  assign n_out     = s4_n;
  assign eig_out   = s4_eig;
  assign sgn_out   = s4_sgn;

endmodule

/* rtl/efmrs_sel.sv */
module efmrs_sel import efmrs_pkg::*; #(
  parameter int VW = VEC_WIDTH_DEF,
  parameter int EW = EIG_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [VW-1:0] e_in   [3][3],
  input  logic signed [VW-1:0] n_in   [3][3],
  input  logic signed [EW-1:0] eig_in [3],
  input  det_sign_t            sgn_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [EW-1:0] eig_out [3],
  output logic signed [VW-1:0] mat_out [3][3]
);

  localparam int SW = VW + 2;

  typedef struct packed {
    logic signed [SW-1:0] score;
    logic [2:0]           ord;
    logic [1:0]           sg;
    logic                 neg2;
  } node_t;

  // later candidate wins only on a strictly larger trace
  function automatic node_t pick(input node_t a, input node_t b);
    return (b.score > a.score) ? b : a;
  endfunction

  logic v5, v6, v7;
  logic rdy5, rdy6, rdy7;

  logic signed [VW-1:0] s5_e [3][3], s5_n [3][3];
  logic signed [VW-1:0] s6_e [3][3], s6_n [3][3];
  logic signed [EW-1:0] s5_eig [3], s6_eig [3];
  node_t                s5_node [12];
  node_t                s6_node [3];
  logic signed [EW-1:0] eig_q [3];
  logic signed [VW-1:0] mat_q [3][3];

  node_t                cand [NUM_CAND];
  node_t                l12_next [12];
  node_t                l3_next [3];
  logic signed [EW-1:0] eig_next [3];
  logic signed [VW-1:0] mat_next [3][3];

  assign rdy7     = !v7 || out_ready;
  assign rdy6     = !v6 || rdy7;
  assign rdy5     = !v5 || rdy6;
  assign in_ready = rdy5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy5) v5 <= in_valid;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  // candidate scores with third-column sign, then first reduction level
  always_comb begin
    logic [2:0]           o;
    logic [1:0]           g;
    logic [1:0]           p0, p1, p2;
    logic [2:0]           ver;
    logic [2:0]           d;
    logic                 dn;
    logic signed [VW-1:0] t0, t1, t2;
    for (int i = 0; i < NUM_ORD; i++) begin
      for (int j = 0; j < NUM_SIGN; j++) begin
        o   = 3'(i);
        g   = 2'(j);
        p0  = perm_col(o, 2'd0);
        p1  = perm_col(o, 2'd1);
        p2  = perm_col(o, 2'd2);
        ver = 3'b000;
        ver[p0] = g[1];
        ver[p1] = g[0];
        d   = {ver[0], ver[1], ver[2]};
        dn  = perm_odd(o) ? sgn_in.pos[d] : sgn_in.neg[d];
        t0  = g[1] ? n_in[0][p0] : e_in[0][p0];
        t1  = g[0] ? n_in[1][p1] : e_in[1][p1];
        t2  = dn   ? n_in[2][p2] : e_in[2][p2];
        cand[i*NUM_SIGN + j].score = SW'(t0) + SW'(t1) + SW'(t2);
        cand[i*NUM_SIGN + j].ord   = o;
        cand[i*NUM_SIGN + j].sg    = g;
        cand[i*NUM_SIGN + j].neg2  = dn;
      end
    end
    for (int k = 0; k < 12; k++) begin
      l12_next[k] = pick(cand[2*k], cand[2*k+1]);
    end
  end

  // 12 to 6 to 3
  always_comb begin
    node_t l6 [6];
    for (int k = 0; k < 6; k++) begin
      l6[k] = pick(s5_node[2*k], s5_node[2*k+1]);
    end
    for (int k = 0; k < 3; k++) begin
      l3_next[k] = pick(l6[2*k], l6[2*k+1]);
    end
  end

  // final pick and frame assembly
  always_comb begin
    node_t      w;
    logic [1:0] p0, p1, p2;
    w  = pick(pick(s6_node[0], s6_node[1]), s6_node[2]);
    p0 = perm_col(w.ord, 2'd0);
    p1 = perm_col(w.ord, 2'd1);
    p2 = perm_col(w.ord, 2'd2);
    eig_next[0] = s6_eig[p0];
    eig_next[1] = s6_eig[p1];
    eig_next[2] = s6_eig[p2];
    for (int r = 0; r < 3; r++) begin
      mat_next[r][0] = w.sg[1] ? s6_n[r][p0] : s6_e[r][p0];
      mat_next[r][1] = w.sg[0] ? s6_n[r][p1] : s6_e[r][p1];
      mat_next[r][2] = w.neg2  ? s6_n[r][p2] : s6_e[r][p2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_e    <= e_in;
      s5_n    <= n_in;
      s5_eig  <= eig_in;
      s5_node <= l12_next;
    end
    if (rdy6) begin
      s6_e    <= s5_e;
      s6_n    <= s5_n;
      s6_eig  <= s5_eig;
      s6_node <= l3_next;
    end
    if (rdy7) begin
      eig_q <= eig_next;
      mat_q <= mat_next;
    end
  end

  assign out_valid = v7;
  assign eig_out   = eig_q;
  assign mat_out   = mat_q;

endmodule

/* rtl/eigenframe_min_rotation_select_top.sv */
// seven register stages lie between an accepted request and its result
// throughput: one request per cycle while the output is not stalled, set by the seven-stage pipeline
// the output register holds a result under stall while earlier stages keep filling
// reset (synchronous, active high) clears only the stage valid bits
module eigenframe_min_rotation_select_top import efmrs_pkg::*; #(
  parameter int VEC_WIDTH = VEC_WIDTH_DEF,
  parameter int EIG_WIDTH = EIG_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst,
  efmrs_in_if.sink    in_ch,
  efmrs_out_if.source out_ch
);

  logic signed [VEC_WIDTH-1:0] e_in [3][3];
  logic signed [EIG_WIDTH-1:0] eig_in [3];
  logic signed [VEC_WIDTH-1:0] d_e [3][3], d_n [3][3];
  logic signed [EIG_WIDTH-1:0] d_eig [3];
  det_sign_t                   d_sgn;
  logic                        d_valid, d_ready;
  logic signed [EIG_WIDTH-1:0] o_eig [3];
  logic signed [VEC_WIDTH-1:0] o_mat [3][3];

  // unpack request
  assign eig_in[0]  = in_ch.eigval_0;
  assign eig_in[1]  = in_ch.eigval_1;
  assign eig_in[2]  = in_ch.eigval_2;
  assign e_in[0][0] = in_ch.e_r0c0;
  assign e_in[0][1] = in_ch.e_r0c1;
  assign e_in[0][2] = in_ch.e_r0c2;
  assign e_in[1][0] = in_ch.e_r1c0;
  assign e_in[1][1] = in_ch.e_r1c1;
  assign e_in[1][2] = in_ch.e_r1c2;
  assign e_in[2][0] = in_ch.e_r2c0;
  assign e_in[2][1] = in_ch.e_r2c1;
  assign e_in[2][2] = in_ch.e_r2c2;

  // determinant signs for all column versions
  efmrs_det #(
    .VW (VEC_WIDTH),
    .EW (EIG_WIDTH)
  ) u_det (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .e_in      (e_in),
    .eig_in    (eig_in),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .e_out     (d_e),
    .n_out     (d_n),
    .eig_out   (d_eig),
    .sgn_out   (d_sgn)
  );

  // candidate scoring and selection
  efmrs_sel #(
    .VW (VEC_WIDTH),
    .EW (EIG_WIDTH)
  ) u_sel (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .e_in      (d_e),
    .n_in      (d_n),
    .eig_in    (d_eig),
    .sgn_in    (d_sgn),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .eig_out   (o_eig),
    .mat_out   (o_mat)
  );

  // pack result
  assign out_ch.out_eigval_0 = o_eig[0];
  assign out_ch.out_eigval_1 = o_eig[1];
  assign out_ch.out_eigval_2 = o_eig[2];
  assign out_ch.o_r0c0       = o_mat[0][0];
  assign out_ch.o_r0c1       = o_mat[0][1];
  assign out_ch.o_r0c2       = o_mat[0][2];
  assign out_ch.o_r1c0       = o_mat[1][0];
  assign out_ch.o_r1c1       = o_mat[1][1];
  assign out_ch.o_r1c2       = o_mat[1][2];
  assign out_ch.o_r2c0       = o_mat[2][0];
  assign out_ch.o_r2c1       = o_mat[2][1];
  assign out_ch.o_r2c2       = o_mat[2][2];

endmodule
